@@ rtl/glfsr_pkg.sv @@
// ----------------------------------------------------------------------------
// glfsr_pkg
// Shared types, constants and the tap table for the selectable-width Galois
// LFSR.
// ----------------------------------------------------------------------------
package glfsr_pkg;

    // Register geometry
    localparam int MAX_WIDTH = 30;
    localparam int MIN_WIDTH = 3;
    localparam int CFG_W     = 5;
    localparam int RESET_WIDTH = 8;

    typedef logic [MAX_WIDTH-1:0] word_t;
    typedef logic [CFG_W-1:0]     width_t;

    // Item operations
    typedef enum logic [0:0] {
        OP_STEP = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // One input item as held in the input register
    typedef struct packed {
        op_t   operation;
        word_t seed_value;
    } item_t;

    // Feedback taps per width (bit numbers of the inverted positions); width 16 has no entry and gets no taps
    function automatic word_t tap_mask(input width_t w);
        word_t m;
        begin
            case (w)
                5'd3:    m = 30'h0000_0004;
                5'd4:    m = 30'h0000_0008;
                5'd5:    m = 30'h0000_0008;
                5'd6:    m = 30'h0000_0020;
                5'd7:    m = 30'h0000_0040;
                5'd8:    m = 30'h0000_008C;
                5'd9:    m = 30'h0000_0020;
                5'd10:   m = 30'h0000_0080;
                5'd11:   m = 30'h0000_0200;
                5'd12:   m = 30'h0000_0320;
                5'd13:   m = 30'h0000_1600;
                5'd14:   m = 30'h0000_200C;
                5'd15:   m = 30'h0000_4000;
                5'd17:   m = 30'h0000_4000;
                5'd18:   m = 30'h0000_0800;
                5'd19:   m = 30'h0004_6000;
                5'd20:   m = 30'h0002_0000;
                5'd21:   m = 30'h0008_0000;
                5'd22:   m = 30'h0020_0000;
                5'd23:   m = 30'h0004_0000;
                5'd24:   m = 30'h00B0_0000;
                5'd25:   m = 30'h0040_0000;
                5'd26:   m = 30'h020C_0000;
                5'd27:   m = 30'h0418_0000;
                5'd28:   m = 30'h0200_0000;
                5'd29:   m = 30'h0800_0000;
                5'd30:   m = 30'h2000_C000;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

@@ rtl/glfsr_step.sv @@
// ----------------------------------------------------------------------------
// glfsr_step
// Next-state logic: one Galois step or a masked seed load, within the
// configured width.
// ----------------------------------------------------------------------------
module glfsr_step (
    input  glfsr_pkg::item_t  item,
    input  glfsr_pkg::word_t  state_cur,
    input  glfsr_pkg::width_t width_cfg,
    output glfsr_pkg::word_t  state_nxt
);

    glfsr_pkg::width_t w_used;
    glfsr_pkg::width_t top_pos;
    glfsr_pkg::word_t  mask;
    glfsr_pkg::word_t  x_in;
    glfsr_pkg::word_t  x_fb;
    glfsr_pkg::word_t  x_rot;
    logic              low_bit;

    // Width in use, saturated to the supported range
    always_comb
    begin
        if (width_cfg < glfsr_pkg::width_t'(glfsr_pkg::MIN_WIDTH))
            w_used = glfsr_pkg::width_t'(glfsr_pkg::MIN_WIDTH);
        else if (width_cfg > glfsr_pkg::width_t'(glfsr_pkg::MAX_WIDTH))
            w_used = glfsr_pkg::width_t'(glfsr_pkg::MAX_WIDTH);
        else
            w_used = width_cfg;
    end

    // Mask of the bits in use; shifting by the full width gives all ones
    assign mask    = ~({glfsr_pkg::MAX_WIDTH{1'b1}} << w_used);
    assign top_pos = w_used - glfsr_pkg::width_t'(1);

    // Feedback: invert taps when bit 0 is set, then rotate right in width
    assign x_in    = state_cur & mask;
    assign low_bit = x_in[0];
    assign x_fb    = low_bit ? (x_in ^ (glfsr_pkg::tap_mask(w_used) & mask)) : x_in;
    assign x_rot   = ((x_fb >> 1) | (glfsr_pkg::word_t'(low_bit) << top_pos)) & mask;

    // Load or step
    always_comb
    begin
        case (item.operation)
            glfsr_pkg::OP_LOAD: state_nxt = item.seed_value & mask;
            default:            state_nxt = x_rot;
        endcase
    end

endmodule

@@ rtl/galois_lfsr_selectable_width_top.sv @@
// Pipeline: an input transfer passes the input register, then the state and
// result registers.
// Throughput: one item per cycle while the output is not stalled; the state
// feedback loop is a single registered pass through the step logic.
// Reset: state word 1, width 8, both pipeline stages empty.
// ----------------------------------------------------------------------------
// galois_lfsr_selectable_width_top
// Galois LFSR of configurable width (3 to 30 bits) with step and load items.
// ----------------------------------------------------------------------------
module galois_lfsr_selectable_width_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  glfsr_pkg::width_t        cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic [29:0]              seed_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [29:0]              state_value
);

    glfsr_pkg::width_t width_reg;
    glfsr_pkg::item_t  item_reg;
    logic              item_valid_reg;
    glfsr_pkg::word_t  state_reg;
    glfsr_pkg::word_t  state_next;
    glfsr_pkg::word_t  result_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_xfer;

    // Pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !item_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // Width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= glfsr_pkg::width_t'(glfsr_pkg::RESET_WIDTH);
        else if (cfg_wr_en)
            width_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.operation  <= glfsr_pkg::op_t'(operation);
            item_reg.seed_value <= seed_value;
        end
    end

    // Step logic
    glfsr_step u_step (
        .item      (item_reg),
        .state_cur (state_reg),
        .width_cfg (width_reg),
        .state_nxt (state_next)
    );

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glfsr_pkg::word_t'(1);
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
            if (item_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
            result_reg <= state_next;
    end

    assign out_valid   = out_valid_reg;
    assign state_value = result_reg;

endmodule

@@ rtl/glfsr_checker.sv @@
// ----------------------------------------------------------------------------
// glfsr_checker
// Port-level checks on the LFSR top level, bound to every instance.
// ----------------------------------------------------------------------------
module glfsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [29:0] state_value
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(state_value))
        else $error("result changed or dropped while stalled");

    // Output stage empty means the input side can take a transfer
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // Every input transfer shows a result once it has passed the input register and the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("result missing two cycles after input transfer");

    // No result straight after reset release
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid at reset release");

endmodule

bind galois_lfsr_selectable_width_top glfsr_checker u_glfsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .state_value (state_value)
);
